[design/zone_hysteresis_tracker_top_defines.svh]
// Assertion macros used by the zone hysteresis tracker top module.
`ifndef ZONE_HYSTERESIS_TRACKER_TOP_DEFINES_SVH
`define ZONE_HYSTERESIS_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define ZHT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone tracker assertion failed");
// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define ZHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zone tracker assertion failed");
`else
`define ZHT_ASSERT_IMPL(lbl, ante, cons)
`define ZHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/zht_pkg.sv]
// Package with types, constants and register indexes of the zone hysteresis tracker.
`timescale 1ns / 1ps

package zht_pkg;

    localparam int RATIO_FRAC_BITS = 16;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
    localparam int COUNT_BITS      = 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = RATIO_W;

    typedef logic [RATIO_W-1:0]    ratio_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [1:0] {
        ZONE_NONE   = 2'd0,
        ZONE_LEFT   = 2'd1,
        ZONE_CENTER = 2'd2,
        ZONE_RIGHT  = 2'd3
    } zone_t;

    // Configuration register indexes.
    localparam cfg_addr_t CFG_KEEP_THRESHOLD  = 2'd0;
    localparam cfg_addr_t CFG_ENTER_THRESHOLD = 2'd1;
    localparam cfg_addr_t CFG_SWITCH_MARGIN   = 2'd2;
    localparam cfg_addr_t CFG_CONFIRM_NEEDED  = 2'd3;

    // Reset values of the configuration registers.
    localparam ratio_t KEEP_THRESHOLD_RST  = ratio_t'(26214);
    localparam ratio_t ENTER_THRESHOLD_RST = ratio_t'(32768);
    localparam ratio_t SWITCH_MARGIN_RST   = ratio_t'(6554);
    localparam count_t CONFIRM_NEEDED_RST  = count_t'(3);

    typedef struct packed {
        ratio_t ratio_left;
        ratio_t ratio_center;
        ratio_t ratio_right;
    } in_item_t;

    typedef struct packed {
        logic [1:0] zone_out;
        logic [1:0] pending_zone_out;
        count_t     pending_count_out;
    } out_item_t;

    typedef struct packed {
        ratio_t keep_threshold;
        ratio_t enter_threshold;
        ratio_t switch_margin;
        count_t confirm_needed;
    } zht_cfg_t;

    typedef struct packed {
        zone_t  current_zone;
        zone_t  pending_zone;
        count_t pending_count;
    } trk_state_t;

endpackage

[design/zone_hysteresis_tracker_top.sv]
// Top level of the zone hysteresis tracker: input register, tracking state and result register.
`timescale 1ns / 1ps
// The tracker takes one frame per transaction on the input channel (in_valid, in_ready,
// in_data), holding the left, center and right zone ratios in unsigned Q1.16. For each
// frame it returns exactly one result transaction on the output channel (out_valid,
// out_ready, out_data): the held zone, the pending candidate and its frame count, all
// taken after the frame has been applied.
// A frame accepted at a clock edge is latched in the input register; once the result
// register is free, the decision logic updates the tracking state and loads the result
// register, which then offers the result on the output channel.
// Throughput is one frame per cycle while out_ready is high; the decision is a three-way
// compare, one subtract and a counter update between the input and result registers.
// When the receiver stalls, the result register holds its transaction and the input
// register can still take one more frame; in_ready drops only while both are full and
// out_ready is low.
// Thresholds are written through cfg_we, cfg_addr and cfg_wdata while no frame is in
// flight. Reset (rst_n low) empties both registers, clears the held zone and the pending
// candidate, and restores the default thresholds.
`include "zone_hysteresis_tracker_top_defines.svh"

module zone_hysteresis_tracker_top
    import zht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  cfg_addr_t cfg_addr,
    input  cfg_data_t cfg_wdata
);

    zht_cfg_t   cfg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_data_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_data_reg;

    trk_state_t state_reg;
    trk_state_t state_next;

    logic       out_free;
    logic       s1_adv;
    logic       in_take;

    zht_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    zht_decide u_decide (
        .frame     (s1_data_reg),
        .cfg       (cfg),
        .state_cur (state_reg),
        .state_new (state_next)
    );

    // The result register is free when empty or when its transaction completes now.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !s1_adv);
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{current_zone: ZONE_NONE, pending_zone: ZONE_NONE,
                               pending_count: '0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg.zone_out          <= state_next.current_zone;
            out_data_reg.pending_zone_out  <= state_next.pending_zone;
            out_data_reg.pending_count_out <= state_next.pending_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pending candidate always has a nonzero count, and no candidate means a zero count.
    `ZHT_ASSERT_IMPL(a_pending_consistent, 1'b1,
        (state_reg.pending_zone == ZONE_NONE) == (state_reg.pending_count == '0))
    // A loaded result mirrors the tracking state it was taken from.
    `ZHT_ASSERT_NEXT(a_result_matches_state, s1_adv,
        out_valid_reg && (out_data_reg.zone_out == state_reg.current_zone) &&
        (out_data_reg.pending_count_out == state_reg.pending_count))
    // Tracking state only moves when a frame is processed.
    `ZHT_ASSERT_NEXT(a_state_holds_when_idle, !s1_adv, $stable(state_reg))
    // Input backpressure only comes from a stalled, full result register.
    `ZHT_ASSERT_IMPL(a_ready_only_on_stall, !in_ready,
        s1_valid_reg && out_valid_reg && !out_ready)

endmodule

[design/zht_cfg_regs.sv]
// Configuration register file of the zone hysteresis tracker.
`timescale 1ns / 1ps

module zht_cfg_regs
    import zht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_addr_t cfg_addr,
    input  cfg_data_t cfg_wdata,
    output zht_cfg_t  cfg
);

    zht_cfg_t cfg_reg;
    zht_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KEEP_THRESHOLD:  cfg_next.keep_threshold  = ratio_t'(cfg_wdata);
                CFG_ENTER_THRESHOLD: cfg_next.enter_threshold = ratio_t'(cfg_wdata);
                CFG_SWITCH_MARGIN:   cfg_next.switch_margin   = ratio_t'(cfg_wdata);
                CFG_CONFIRM_NEEDED:  cfg_next.confirm_needed  = cfg_wdata[COUNT_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_threshold  <= KEEP_THRESHOLD_RST;
            cfg_reg.enter_threshold <= ENTER_THRESHOLD_RST;
            cfg_reg.switch_margin   <= SWITCH_MARGIN_RST;
            cfg_reg.confirm_needed  <= CONFIRM_NEEDED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/zht_decide.sv]
// Combinational zone decision: keep test, arg-max, enter and margin tests, confirm counter.
`timescale 1ns / 1ps

module zht_decide
    import zht_pkg::*;
(
    input  in_item_t   frame,
    input  zht_cfg_t   cfg,
    input  trk_state_t state_cur,
    output trk_state_t state_new
);

    ratio_t     held_ratio;
    ratio_t     best_ratio;
    zone_t      best_zone;
    ratio_t     lead;
    logic       zone_held;
    logic       keep_hit;
    logic       fail;
    trk_state_t counted;

    always_comb
    begin
        case (state_cur.current_zone)
            ZONE_LEFT:   held_ratio = frame.ratio_left;
            ZONE_CENTER: held_ratio = frame.ratio_center;
            ZONE_RIGHT:  held_ratio = frame.ratio_right;
            default:     held_ratio = '0;
        endcase
    end

    // Arg-max with ties going to the lower zone index.
    always_comb
    begin
        best_ratio = frame.ratio_left;
        best_zone  = ZONE_LEFT;
        if (frame.ratio_center > best_ratio)
        begin
            best_ratio = frame.ratio_center;
            best_zone  = ZONE_CENTER;
        end
        if (frame.ratio_right > best_ratio)
        begin
            best_ratio = frame.ratio_right;
            best_zone  = ZONE_RIGHT;
        end
    end

    // The best ratio is never below the held one, so the lead cannot wrap.
    assign lead      = best_ratio - held_ratio;
    assign zone_held = (state_cur.current_zone != ZONE_NONE);
    assign keep_hit  = zone_held && (held_ratio >= cfg.keep_threshold);
    assign fail      = (best_ratio < cfg.enter_threshold) ||
                       (zone_held && (best_zone != state_cur.current_zone) &&
                        (lead < cfg.switch_margin));

    always_comb
    begin
        counted = state_cur;
        if (state_cur.pending_zone == best_zone)
        begin
            if (state_cur.pending_count != '1)
            begin
                counted.pending_count = state_cur.pending_count + count_t'(1);
            end
        end
        else
        begin
            counted.pending_zone  = best_zone;
            counted.pending_count = count_t'(1);
        end
    end

    always_comb
    begin
        state_new = state_cur;
        if (keep_hit || fail)
        begin
            state_new.pending_zone  = ZONE_NONE;
            state_new.pending_count = '0;
        end
        else if (counted.pending_count >= cfg.confirm_needed)
        begin
            state_new.current_zone  = best_zone;
            state_new.pending_zone  = ZONE_NONE;
            state_new.pending_count = '0;
        end
        else
        begin
            state_new = counted;
        end
    end

endmodule
